FILE: rtl/core/keq_pkg.sv
package keq_pkg;

    // sizes
    localparam int NUM_KEYS    = 96;
    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_WIDTH  = 16;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 7;
    localparam int TYPE_W     = 2;
    localparam int KEY_ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_KEY  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP  = 2'd2;

    // event types
    localparam logic [TYPE_W-1:0] TYPE_NONE = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_DOWN = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_UP   = 2'd2;

    localparam logic [KEY_W-1:0] NO_KEY = 7'd127;

    // one queued event
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [TYPE_W-1:0]     ev_type;
        logic [TIME_WIDTH-1:0] stamp;
    } evt_t;

    // key flag store access
    typedef struct packed {
        logic                  rd_en;
        logic [KEY_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [KEY_ADDR_W-1:0] wr_addr;
        logic                  wr_data;
    } flag_ctrl_t;

    // event fifo commands and status
    typedef struct packed {
        logic push;
        logic pop;
        evt_t push_data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        evt_t             head;
    } fifo_stat_t;

endpackage

FILE: rtl/core/keq_flag_store.sv
module keq_flag_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  keq_pkg::flag_ctrl_t ctrl,
    output logic                rd_flag
);
    import keq_pkg::*;

    logic                flag_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] written_reg;
    logic                mem_rd_reg;
    logic                written_rd_reg;

    // flag memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            flag_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en) begin
            mem_rd_reg <= flag_mem[ctrl.rd_addr];
        end
    end

    // written bits stand in for clearing the memory at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            written_rd_reg <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                written_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                written_rd_reg <= written_reg[ctrl.rd_addr];
            end
        end
    end

    // unwritten key reads as released
    assign rd_flag = mem_rd_reg & written_rd_reg;

endmodule

FILE: rtl/core/keq_event_fifo.sv
module keq_event_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  keq_pkg::fifo_ctrl_t ctrl,
    output keq_pkg::fifo_stat_t stat
);
    import keq_pkg::*;

    evt_t             evt_mem [QUEUE_DEPTH];
    evt_t             head_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W:0]   slot_sum;
    logic [PTR_W-1:0] wr_slot;

    // write slot is read pointer plus count, wrapped at the depth
    always_comb begin
        slot_sum = {1'b0, rd_ptr_reg} + (PTR_W + 1)'(count_reg);
        if (slot_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
            wr_slot = PTR_W'(slot_sum - (PTR_W + 1)'(QUEUE_DEPTH));
        end else begin
            wr_slot = slot_sum[PTR_W-1:0];
        end
    end

    // event memory, head read every cycle
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            evt_mem[wr_slot] <= ctrl.push_data;
        end
        head_reg <= evt_mem[rd_ptr_reg];
    end

    // pointer and count update
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        if (ctrl.pop) begin
            if (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        count_next = count_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign stat.count = count_reg;
    assign stat.head  = head_reg;

endmodule

FILE: rtl/core/key_event_queue.sv
// an item commits once its key flag read is registered and the output is free;
//   a new item is accepted only after that commit, as the registered read of the
//   key flag memory comes ahead of the read-modify-write commit
// a waiting result stays in the output register while the next item is read
// reset (aresetn low, synchronous) releases all keys through per-key written
//   bits, empties the queue and zeroes the tick counter; no clearing pass
module key_event_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [keq_pkg::OP_W-1:0]       s_operation,
    input  logic [keq_pkg::KEY_W-1:0]      s_key_index,
    input  logic                           s_key_pressed,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_event_valid,
    output logic [keq_pkg::KEY_W-1:0]      m_event_key,
    output logic [keq_pkg::TYPE_W-1:0]     m_event_type,
    output logic [keq_pkg::TIME_WIDTH-1:0] m_event_time,
    output logic                           m_key_is_down,
    output logic [keq_pkg::CNT_W-1:0]      m_queue_count,
    output logic                           m_overflow
);
    import keq_pkg::*;

    logic                  s_accept;
    logic                  in_key_ok;
    logic                  busy_reg;
    logic [OP_W-1:0]       op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic                  pressed_reg;
    logic [TIME_WIDTH-1:0] tick_reg;
    logic [TIME_WIDTH-1:0] tick_next;

    flag_ctrl_t flag_ctrl;
    logic       cur_flag;
    fifo_ctrl_t fifo_ctrl;
    fifo_stat_t fifo_stat;

    logic commit;
    logic key_ok;
    logic flag_change;
    logic queue_full;
    logic do_push;
    logic do_pop;
    logic new_flag;

    logic                  m_valid_reg;
    logic                  ev_valid_reg;
    logic [KEY_W-1:0]      ev_key_reg;
    logic [TYPE_W-1:0]     ev_type_reg;
    logic [TIME_WIDTH-1:0] ev_time_reg;
    logic                  key_down_reg;
    logic [CNT_W-1:0]      count_out_reg;
    logic                  overflow_reg;

    // one item in flight between flag read and commit
    assign s_ready   = !busy_reg;
    assign s_accept  = s_valid && s_ready;
    assign in_key_ok = (32'(s_key_index) < NUM_KEYS);
    assign commit    = busy_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_accept) begin
            busy_reg <= 1'b1;
        end else if (commit) begin
            busy_reg <= 1'b0;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg      <= s_operation;
            key_reg     <= s_key_index;
            pressed_reg <= s_key_pressed;
        end
    end

    // commit decisions
    always_comb begin
        key_ok      = (32'(key_reg) < NUM_KEYS);
        flag_change = (op_reg == OP_KEY) && key_ok && (cur_flag != pressed_reg);
        queue_full  = (fifo_stat.count == CNT_W'(QUEUE_DEPTH));
        do_push     = commit && flag_change && !queue_full;
        do_pop      = commit && (op_reg == OP_POP) && (fifo_stat.count != '0);
        new_flag    = flag_change ? pressed_reg : cur_flag;
    end

    // flag store access: read at accept, write back at commit
    always_comb begin
        flag_ctrl.rd_en   = s_accept;
        flag_ctrl.rd_addr = in_key_ok ? KEY_ADDR_W'(s_key_index) : '0;
        flag_ctrl.wr_en   = commit && flag_change;
        flag_ctrl.wr_addr = KEY_ADDR_W'(key_reg);
        flag_ctrl.wr_data = pressed_reg;
    end

    keq_flag_store u_flag_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (flag_ctrl),
        .rd_flag (cur_flag)
    );

    // event fifo commands
    always_comb begin
        fifo_ctrl.push              = do_push;
        fifo_ctrl.pop               = do_pop;
        fifo_ctrl.push_data.key     = key_reg;
        fifo_ctrl.push_data.ev_type = pressed_reg ? TYPE_DOWN : TYPE_UP;
        fifo_ctrl.push_data.stamp   = tick_reg;
    end

    keq_event_fifo u_event_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fifo_ctrl),
        .stat    (fifo_stat)
    );

    // tick counter, advanced by each committed tick item
    assign tick_next = (commit && (op_reg == OP_TICK)) ? tick_reg + 1'b1 : tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
        end else begin
            tick_reg <= tick_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            ev_valid_reg  <= do_pop;
            ev_key_reg    <= do_pop ? fifo_stat.head.key : NO_KEY;
            ev_type_reg   <= do_pop ? fifo_stat.head.ev_type : TYPE_NONE;
            ev_time_reg   <= do_pop ? fifo_stat.head.stamp : '0;
            key_down_reg  <= key_ok && new_flag;
            count_out_reg <= fifo_stat.count + CNT_W'(do_push) - CNT_W'(do_pop);
            overflow_reg  <= flag_change && queue_full;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_valid = ev_valid_reg;
    assign m_event_key   = ev_key_reg;
    assign m_event_type  = ev_type_reg;
    assign m_event_time  = ev_time_reg;
    assign m_key_is_down = key_down_reg;
    assign m_queue_count = count_out_reg;
    assign m_overflow    = overflow_reg;

endmodule

FILE: rtl/core/keq_checker.sv
module keq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_event_valid,
    input logic [keq_pkg::KEY_W-1:0]      m_event_key,
    input logic [keq_pkg::TYPE_W-1:0]     m_event_type,
    input logic [keq_pkg::TIME_WIDTH-1:0] m_event_time,
    input logic [keq_pkg::CNT_W-1:0]      m_queue_count,
    input logic                           m_overflow
);
    import keq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_key) && $stable(m_queue_count))
        else $error("result changed while stalled");

    // a popped event is a down or up event
    a_popped_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_valid |-> (m_event_type == TYPE_DOWN || m_event_type == TYPE_UP))
        else $error("popped event has no type");

    // no event means the none fields
    a_none_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_valid |->
            m_event_key == NO_KEY && m_event_type == TYPE_NONE && m_event_time == '0)
        else $error("none event fields wrong");

    // count never exceeds the depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_queue_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // a dropped event only with a full queue and never with a pop
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_queue_count == CNT_W'(QUEUE_DEPTH) && !m_event_valid)
        else $error("overflow without a full queue");

endmodule

bind key_event_queue keq_checker u_keq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_valid (m_event_valid),
    .m_event_key   (m_event_key),
    .m_event_type  (m_event_type),
    .m_event_time  (m_event_time),
    .m_queue_count (m_queue_count),
    .m_overflow    (m_overflow)
);

FILE: bench/testbench.sv
module testbench;
    import keq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic             pressed;
    } key_item_t;

    typedef struct packed {
        logic                  ev_valid;
        logic [KEY_W-1:0]      ev_key;
        logic [TYPE_W-1:0]     ev_type;
        logic [TIME_WIDTH-1:0] ev_time;
        logic                  is_down;
        logic [CNT_W-1:0]      count;
        logic                  ovf;
    } key_step_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation   = OP_TICK;
    logic [KEY_W-1:0]      s_key_index   = '0;
    logic                  s_key_pressed = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_event_valid;
    logic [KEY_W-1:0]      m_event_key;
    logic [TYPE_W-1:0]     m_event_type;
    logic [TIME_WIDTH-1:0] m_event_time;
    logic                  m_key_is_down;
    logic [CNT_W-1:0]      m_queue_count;
    logic                  m_overflow;

    // items still to send and outcomes still to arrive
    key_item_t key_ops_waiting[$];
    key_step_t step_outcomes[$];

    // mirror of the block state, advanced on each accepted item
    bit                    key_held[NUM_KEYS];
    evt_t                  event_ring[QUEUE_DEPTH];
    logic [PTR_W-1:0]      ring_head;
    int unsigned           ring_fill;
    logic [TIME_WIDTH-1:0] tick_now;

    // generation-side view of key flags
    bit                    gen_held[NUM_KEYS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int error_count    = 0;
    int items_in       = 0;
    int results_seen   = 0;
    int pops_returned  = 0;
    int drops_seen     = 0;
    int quiet_cycles   = 0;

    key_event_queue u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_key_index   (s_key_index),
        .s_key_pressed (s_key_pressed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_valid (m_event_valid),
        .m_event_key   (m_event_key),
        .m_event_type  (m_event_type),
        .m_event_time  (m_event_time),
        .m_key_is_down (m_key_is_down),
        .m_queue_count (m_queue_count),
        .m_overflow    (m_overflow)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
        end
        error_count++;
    endtask

    // one key step: tick, key report, pop or nothing
    function automatic key_step_t advance_key_state(key_item_t it);
        key_step_t        r;
        logic             in_range;
        logic [PTR_W-1:0] slot;
        r.ev_valid = 1'b0;
        r.ev_key   = NO_KEY;
        r.ev_type  = TYPE_NONE;
        r.ev_time  = '0;
        r.ovf      = 1'b0;
        in_range   = it.key < NUM_KEYS;
        case (it.op)
            OP_TICK: begin
                tick_now = tick_now + 1'b1;
            end
            OP_KEY: begin
                if (in_range && key_held[it.key] != it.pressed) begin
                    key_held[it.key] = it.pressed;
                    if (ring_fill >= QUEUE_DEPTH) begin
                        r.ovf = 1'b1;
                    end else begin
                        slot = ring_head + ring_fill[PTR_W-1:0];
                        event_ring[slot] = '{key: it.key,
                                             ev_type: it.pressed ? TYPE_DOWN : TYPE_UP,
                                             stamp: tick_now};
                        ring_fill++;
                    end
                end
            end
            OP_POP: begin
                if (ring_fill > 0) begin
                    r.ev_valid = 1'b1;
                    r.ev_key   = event_ring[ring_head].key;
                    r.ev_type  = event_ring[ring_head].ev_type;
                    r.ev_time  = event_ring[ring_head].stamp;
                    ring_head  = ring_head + 1'b1;
                    ring_fill--;
                end
            end
            default: ;
        endcase
        r.is_down = in_range ? key_held[it.key] : 1'b0;
        r.count   = ring_fill[CNT_W-1:0];
        return r;
    endfunction

    // queue an item; returns 1 for a tick, a pop or a key change
    function automatic int add_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                    logic pressed);
        int counts;
        counts = 1;
        key_ops_waiting.push_back('{op: op, key: key, pressed: pressed});
        if (op == OP_KEY) begin
            if (key >= NUM_KEYS) begin
                counts = 0;
            end else if (gen_held[key] == pressed) begin
                counts = 0;
            end else begin
                gen_held[key] = pressed;
            end
        end else if (op != OP_POP && op != OP_TICK) begin
            counts = 0;
        end
        return counts;
    endfunction

    // mostly valid keys, some above the key range
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 15) begin
            return KEY_W'($urandom_range(127, NUM_KEYS));
        end
        return KEY_W'($urandom_range(NUM_KEYS - 1));
    endfunction

    function automatic logic coin();
        return $urandom_range(1) != 0;
    endfunction

    task automatic add_directed();
        void'(add_item(OP_TICK, 7'd5, 1'b0));
        void'(add_item(OP_KEY, 7'd0, 1'b1));
        void'(add_item(OP_KEY, 7'd95, 1'b1));
        // repeated press of a held key: no event
        void'(add_item(OP_KEY, 7'd95, 1'b1));
        // keys beyond the table are ignored
        void'(add_item(OP_KEY, 7'd96, 1'b1));
        void'(add_item(OP_KEY, 7'd127, 1'b0));
        void'(add_item(OP_UNUSED, 7'd0, 1'b1));
        void'(add_item(OP_TICK, 7'd95, 1'b1));
        void'(add_item(OP_POP, 7'd0, 1'b0));
        void'(add_item(OP_POP, 7'd95, 1'b0));
        // pop with nothing queued
        void'(add_item(OP_POP, 7'd3, 1'b1));
        void'(add_item(OP_KEY, 7'd0, 1'b0));
        void'(add_item(OP_POP, 7'd127, 1'b1));
        void'(add_item(OP_POP, 7'd0, 1'b0));
    endtask

    // random mix, bursts of key changes that overflow, and pop runs
    task automatic add_random(int target);
        int made;
        int kind;
        int pick;
        logic [KEY_W-1:0] k;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                repeat ($urandom_range(15, 5)) begin
                    pick = $urandom_range(99);
                    if (pick < 20) begin
                        made += add_item(OP_TICK, pick_key(), coin());
                    end else if (pick < 65) begin
                        made += add_item(OP_KEY, pick_key(), coin());
                    end else if (pick < 95) begin
                        made += add_item(OP_POP, pick_key(), coin());
                    end else begin
                        made += add_item(OP_UNUSED, pick_key(), coin());
                    end
                end
            end else if (kind < 75) begin
                repeat ($urandom_range(22, 17)) begin
                    k = KEY_W'($urandom_range(NUM_KEYS - 1));
                    made += add_item(OP_KEY, k, !gen_held[k]);
                end
            end else begin
                repeat ($urandom_range(20, 8)) begin
                    made += add_item(OP_POP, pick_key(), coin());
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (key_ops_waiting.size() != 0 || step_outcomes.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // item driver
    always @(posedge aclk) begin
        key_item_t cur;
        key_item_t nxt;
        int        i;
        if (!aresetn) begin
            s_valid <= 1'b0;
            for (i = 0; i < NUM_KEYS; i++) begin
                key_held[i] = 1'b0;
            end
            ring_head = '0;
            ring_fill = 0;
            tick_now  = '0;
        end else begin
            if (s_valid && s_ready) begin
                cur = '{op: s_operation, key: s_key_index, pressed: s_key_pressed};
                step_outcomes.push_back(advance_key_state(cur));
                void'(key_ops_waiting.pop_front());
                items_in++;
            end
            if (!s_valid || s_ready) begin
                if (key_ops_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = key_ops_waiting[0];
                    s_valid       <= 1'b1;
                    s_operation   <= nxt.op;
                    s_key_index   <= nxt.key;
                    s_key_pressed <= nxt.pressed;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        key_step_t want;
        int        hold_seen;
        int        hold_left;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (step_outcomes.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 1, 0);
                end else begin
                    want = step_outcomes.pop_front();
                    if (want.ev_valid) pops_returned++;
                    if (want.ovf) drops_seen++;
                    if (m_event_valid !== want.ev_valid)
                        report_mismatch("event_valid", m_event_valid, want.ev_valid);
                    if (m_event_key !== want.ev_key)
                        report_mismatch("event_key", m_event_key, want.ev_key);
                    if (m_event_type !== want.ev_type)
                        report_mismatch("event_type", m_event_type, want.ev_type);
                    if (m_event_time !== want.ev_time)
                        report_mismatch("event_time", m_event_time, want.ev_time);
                    if (m_key_is_down !== want.is_down)
                        report_mismatch("key_is_down", m_key_is_down, want.is_down);
                    if (m_queue_count !== want.count)
                        report_mismatch("queue_count", m_queue_count, want.count);
                    if (m_overflow !== want.ovf)
                        report_mismatch("overflow", m_overflow, want.ovf);
                end
            end
            // long hold-off on request, otherwise random stalls
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, then stimulus phases with different idling
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // no idling, with one long receiver hold-off
        add_directed();
        hold_req++;
        add_random(250);
        wait_drained();

        // sender mostly idle
        send_idle_pct = 70;
        add_random(250);
        wait_drained();

        // receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        add_random(250);
        wait_drained();

        // both sides idling a third of the time
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        add_random(250);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (step_outcomes.size() != 0) begin
            report_mismatch("results never arrived", step_outcomes.size(), 0);
        end

        $display("covered %0d items and %0d results over four idling phases",
                 items_in, results_seen);
        $display("%0d events popped, %0d events dropped on a full queue, %0d mismatches",
                 pops_returned, drops_seen, error_count);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/keq_pkg.sv
rtl/core/keq_flag_store.sv
rtl/core/keq_event_fifo.sv
rtl/core/key_event_queue.sv
rtl/core/keq_checker.sv
bench/testbench.sv
